/* sv/fpr_pkg.sv */
// Shared types, constants and helper functions of the fixed packet record packetizer.
package fpr_pkg;

	// Packet geometry. Everything below is derived from the packet size.
	localparam int PACKET_BYTES = 512;
	localparam int WORD_COUNT   = (PACKET_BYTES + 7) / 8;
	localparam int WORD_W       = $clog2(WORD_COUNT);
	localparam int FILL_W       = $clog2(PACKET_BYTES + 1);
	localparam int CMP_W        = ((FILL_W > 9) ? FILL_W : 9) + 2;
	localparam int LAST_LANES   = PACKET_BYTES - (WORD_COUNT - 1) * 8;

	// Header sizes with and without the timestamp.
	localparam int HDR_TS    = 10;
	localparam int HDR_PLAIN = 1;

	localparam logic [7:0] PAD_FILL = 8'hFF;

	// Configuration register indexes and reset values.
	localparam int         CFG_IDX_W      = 2;
	localparam logic [1:0] CFG_SYNC_TAG   = 2'd0;
	localparam logic [1:0] CFG_TS_TAG     = 2'd1;
	localparam logic [1:0] CFG_PAD_TAG    = 2'd2;
	localparam logic [7:0] SYNC_TAG_RST   = 8'd0;
	localparam logic [7:0] TS_TAG_RST     = 8'd1;
	localparam logic [7:0] PAD_TAG_RST    = 8'd255;

	// Result kinds.
	localparam logic KIND_WORD  = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef enum logic [2:0] {
		OP_OPEN   = 3'd0,
		OP_RECORD = 3'd1,
		OP_DATA   = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_CLOSE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ERR_NOT_OPEN   = 2'd0,
		ERR_TOO_LARGE  = 2'd1,
		ERR_UNEXPECTED = 2'd2
	} err_t;

	// Byte lanes of the final word that lie inside the packet.
	function automatic logic [63:0] last_word_mask();
		logic [63:0] m;
		m = '0;
		for (int k = 0; k < 8; k++) begin
			if (k < LAST_LANES) begin
				m[8*k +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	localparam logic [63:0] LAST_WORD_MASK = last_word_mask();

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear_left;
		logic put;
		logic put_tag;
		logic start;
		logic pad_first;
		logic pad_fill;
		logic emit;
		logic report;
		err_t code;
	} fpr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic left_zero;
		logic fill_full;
		logic too_large;
		logic no_fit;
		logic out_room;
		logic emit_last;
	} fpr_status_t;

endpackage

/* sv/fpr_datapath.sv */
// Datapath: configuration registers, item registers, packet memory, word assembly and output register.
module fpr_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data,
	input  logic [7:0]                   record_tag,
	input  logic [8:0]                   record_length,
	input  logic [7:0]                   data_byte,
	input  logic [63:0]                  time_value,
	input  logic                         time_valid,
	input  fpr_pkg::fpr_cmd_t            cmd,
	output fpr_pkg::fpr_status_t         status,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic                         kind,
	output logic [63:0]                  packet_word,
	output logic                         last,
	output logic [1:0]                   error
);
	import fpr_pkg::*;

	logic [7:0]        sync_tag_q, ts_tag_q, pad_tag_q;
	logic [7:0]        tag_q;
	logic [8:0]        len_q;
	logic [63:0]       tv_q;
	logic              tvalid_q;
	logic [63:0]       acc_q;
	logic [FILL_W-1:0] fill_q;
	logic [8:0]        left_q;
	logic [63:0]       mem [WORD_COUNT];
	logic [63:0]       rd_q;
	logic [WORD_W-1:0] rd_ptr_q;
	logic              out_valid_q, kind_q, last_q;
	logic [1:0]        err_q;

	logic [2:0]        lane;
	logic [WORD_W-1:0] widx;
	logic              last_word, fill_full, put_ok, put_done;
	logic [FILL_W-1:0] next_bound;
	logic [7:0]        put_val;
	logic [63:0]       put_word, pad_word, fill_word;
	logic              wr_en;
	logic [WORD_W-1:0] wr_addr;
	logic [63:0]       wr_data;
	logic [CMP_W-1:0]  need, hdr;
	logic              out_room, emit_go, report_go, rd_last;

	assign lane       = fill_q[2:0];
	assign widx       = fill_q[WORD_W+2:3];
	assign last_word  = (widx == WORD_W'(WORD_COUNT - 1));
	assign fill_full  = (fill_q >= FILL_W'(PACKET_BYTES));
	assign next_bound = last_word ? FILL_W'(PACKET_BYTES)
	                              : FILL_W'({widx, 3'b000}) + FILL_W'(8);
	assign put_val    = cmd.put_tag ? tag_q : data_byte;
	assign put_ok     = cmd.put && !fill_full;
	assign put_done   = (lane == 3'd7) || (fill_q == FILL_W'(PACKET_BYTES - 1));

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			put_word[8*k +: 8] = (3'(k) == lane) ? put_val : acc_q[8*k +: 8];
			if (3'(k) < lane) begin
				pad_word[8*k +: 8] = acc_q[8*k +: 8];
			end else if (3'(k) == lane) begin
				pad_word[8*k +: 8] = pad_tag_q;
			end else begin
				pad_word[8*k +: 8] = PAD_FILL;
			end
		end
		fill_word = {8{PAD_FILL}};
		if (last_word) begin
			pad_word  = pad_word & LAST_WORD_MASK;
			fill_word = fill_word & LAST_WORD_MASK;
		end
	end

	// One memory write per cycle at most; the controller never issues two writers together.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = widx;
		wr_data = put_word;
		if (cmd.start && tvalid_q) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = {tv_q[47:0], ts_tag_q, sync_tag_q};
		end else if (put_ok && put_done) begin
			wr_en = 1'b1;
		end else if (cmd.pad_first && !fill_full) begin
			wr_en   = 1'b1;
			wr_data = pad_word;
		end else if (cmd.pad_fill && !fill_full) begin
			wr_en   = 1'b1;
			wr_data = fill_word;
		end
	end

	assign need = CMP_W'(len_q) + CMP_W'(1);
	assign hdr  = tvalid_q ? CMP_W'(HDR_TS) : CMP_W'(HDR_PLAIN);

	assign out_room  = !out_valid_q || !out_stall;
	assign emit_go   = cmd.emit && out_room;
	assign report_go = cmd.report && out_room;
	assign rd_last   = (rd_ptr_q == WORD_W'(WORD_COUNT - 1));

	assign status.left_zero = (left_q == 9'd0);
	assign status.fill_full = fill_full;
	assign status.too_large = need > (CMP_W'(PACKET_BYTES) - hdr);
	assign status.no_fit    = need > (CMP_W'(PACKET_BYTES) - CMP_W'(fill_q));
	assign status.out_room  = out_room;
	assign status.emit_last = emit_go && rd_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_tag_q  <= SYNC_TAG_RST;
			ts_tag_q    <= TS_TAG_RST;
			pad_tag_q   <= PAD_TAG_RST;
			fill_q      <= '0;
			left_q      <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_SYNC_TAG: sync_tag_q <= cfg_data;
					CFG_TS_TAG:   ts_tag_q   <= cfg_data;
					CFG_PAD_TAG:  pad_tag_q  <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.start) begin
				fill_q <= tvalid_q ? FILL_W'(HDR_TS) : FILL_W'(HDR_PLAIN);
			end else if (put_ok) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if ((cmd.pad_first || cmd.pad_fill) && !fill_full) begin
				fill_q <= next_bound;
			end

			if (cmd.clear_left) begin
				left_q <= '0;
			end else if (put_ok) begin
				left_q <= cmd.put_tag ? len_q : left_q - 9'd1;
			end

			if (emit_go) begin
				rd_ptr_q <= rd_last ? '0 : rd_ptr_q + WORD_W'(1);
			end

			if (emit_go || report_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q    <= record_tag;
			len_q    <= record_length;
			tv_q     <= time_value;
			tvalid_q <= time_valid;
		end

		// The word under assembly; lanes not yet written stay zero.
		if (cmd.start) begin
			acc_q <= tvalid_q ? {48'd0, tv_q[63:48]} : {56'd0, sync_tag_q};
		end else if (put_ok) begin
			acc_q <= put_done ? '0 : put_word;
		end else if (cmd.pad_first && !fill_full) begin
			acc_q <= '0;
		end

		if (emit_go) begin
			kind_q <= KIND_WORD;
			last_q <= rd_last;
			err_q  <= '0;
		end else if (report_go) begin
			kind_q <= KIND_ERROR;
			last_q <= 1'b0;
			err_q  <= cmd.code;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rd_q <= mem[rd_ptr_q];
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign packet_word = (kind_q == KIND_ERROR) ? '0 : rd_q;
	assign last        = last_q;
	assign error       = err_q;

endmodule

/* sv/fpr_ctrl.sv */
// Controller: sequences each item through check, padding, emission and packet start.
module fpr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2:0]           operation,
	output logic                 in_stall,
	input  fpr_pkg::fpr_status_t status,
	output fpr_pkg::fpr_cmd_t    cmd
);
	import fpr_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_REC_CHECK = 8'b0000_0010,
		S_PAD_FIRST = 8'b0000_0100,
		S_PAD_FILL  = 8'b0000_1000,
		S_EMIT      = 8'b0001_0000,
		S_START     = 8'b0010_0000,
		S_PUT_TAG   = 8'b0100_0000,
		S_REPORT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   open_q, open_d;
	op_t    op_q, op_d;
	err_t   code_q, code_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		open_d   = open_q;
		op_d     = op_q;
		code_d   = code_q;
		cmd      = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d        = op_t'(operation);
					cmd.capture = 1'b1;
					if (op_d == OP_OPEN) begin
						open_d         = 1'b1;
						cmd.clear_left = 1'b1;
						state_d        = S_START;
					end else if (!open_q
					             && (op_d inside {OP_RECORD, OP_DATA, OP_FLUSH, OP_CLOSE})) begin
						code_d  = ERR_NOT_OPEN;
						state_d = S_REPORT;
					end else begin
						case (op_d)
							OP_RECORD: begin
								cmd.clear_left = 1'b1;
								state_d        = S_REC_CHECK;
							end
							OP_DATA: begin
								if (status.left_zero || status.fill_full) begin
									code_d  = ERR_UNEXPECTED;
									state_d = S_REPORT;
								end else begin
									cmd.put = 1'b1;
								end
							end
							OP_FLUSH, OP_CLOSE: begin
								cmd.clear_left = 1'b1;
								state_d        = S_PAD_FIRST;
							end
							default: ;
						endcase
					end
				end
			end
			S_REC_CHECK: begin
				if (status.too_large) begin
					code_d  = ERR_TOO_LARGE;
					state_d = S_REPORT;
				end else if (status.no_fit) begin
					state_d = S_PAD_FIRST;
				end else begin
					cmd.put     = 1'b1;
					cmd.put_tag = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_PAD_FIRST: begin
				if (status.fill_full) begin
					state_d = S_EMIT;
				end else begin
					cmd.pad_first = 1'b1;
					state_d       = S_PAD_FILL;
				end
			end
			S_PAD_FILL: begin
				if (status.fill_full) begin
					state_d = S_EMIT;
				end else begin
					cmd.pad_fill = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_last) begin
					if (op_q == OP_CLOSE) begin
						open_d  = 1'b0;
						state_d = S_IDLE;
					end else begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = (op_q == OP_RECORD) ? S_PUT_TAG : S_IDLE;
			end
			S_PUT_TAG: begin
				cmd.put     = 1'b1;
				cmd.put_tag = 1'b1;
				state_d     = S_IDLE;
			end
			S_REPORT: begin
				if (status.out_room) begin
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q  <= 1'b0;
			op_q    <= OP_OPEN;
			code_q  <= ERR_NOT_OPEN;
		end else begin
			state_q <= state_d;
			open_q  <= open_d;
			op_q    <= op_d;
			code_q  <= code_d;
		end
	end

endmodule

/* sv/fixed_packet_record_packetizer_top.sv */
// Top level of the fixed packet record packetizer: controller plus datapath.
//
// The block packs tagged records into fixed packets of PACKET_BYTES bytes and
// emits each finished packet as a burst of 64-bit words, first byte in bits 7..0,
// with last set on the final word. A packet opens with the sync tag and, when the
// item that starts it carries a valid time, the timestamp tag and the time in
// little-endian order. A record start places its tag byte and arms a count of
// data bytes; each data byte item then writes one byte. A record that does not
// fit pads and emits the current packet and starts a new one first. Flush and
// close pad with the padding tag and 0xFF bytes and emit; close also leaves the
// open state. Misuse produces an error report item (kind set) instead of data.
// A data byte item is taken without a stall, so a record body streams at one byte
// per cycle. Open starts a new packet; a record start that fits goes through its
// size check and places its tag. A report for an item sent while closed or for a
// surplus data byte waits until the output register is free; a refused record
// start goes through its size check first. Flush and close are accepted, pad the
// packet word by word until it is full (or only see it full when it already
// is), then emit WORD_COUNT words (64 for 512-byte packets) at one word per
// cycle while the output side does not stall. Flush then starts the next
// packet; close goes straight back to idle. A record start that overflows
// runs its size check before the padding, and after the emission starts the
// new packet and then places its tag.
// The emission rate is set by the single read port of the packet memory, whose
// registered read data is also the output register. The packet memory has no
// reset; every byte is written before it is emitted.
module fixed_packet_record_packetizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    record_tag,
	input  logic [8:0]                    record_length,
	input  logic [7:0]                    data_byte,
	input  logic [63:0]                   time_value,
	input  logic                          time_valid,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [63:0]                   packet_word,
	output logic                          last,
	output logic [1:0]                    error
);
	import fpr_pkg::*;

	fpr_cmd_t    cmd;
	fpr_status_t status;

	// The controller owns the open state and the item sequence; it accepts an
	// item only in its idle state.
	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the tags, the packet memory, the fill level, the
	// remaining record byte count and the output register.
	fpr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.record_tag    (record_tag),
		.record_length (record_length),
		.data_byte     (data_byte),
		.time_value    (time_value),
		.time_valid    (time_valid),
		.cmd           (cmd),
		.status        (status),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.kind          (kind),
		.packet_word   (packet_word),
		.last          (last),
		.error         (error)
	);

endmodule

/* sv/fpr_checker.sv */
// Port-level checker of the fixed packet record packetizer and its bind statement.
module fpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [63:0] packet_word,
	input logic        last,
	input logic [1:0]  error
);
	import fpr_pkg::*;

	// A stalled item stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output item dropped");

	// A stalled item keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(packet_word) && $stable(kind)
			&& $stable(last) && $stable(error))
		else $error("stalled output item changed");

	// While a packet burst is under way no new input item is taken.
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_WORD) && !last |-> in_stall)
		else $error("input accepted in the middle of a packet burst");

endmodule

bind fixed_packet_record_packetizer_top fpr_checker u_fpr_checker (.*);

/* dv/tb_fixed_packet_record_packetizer_top.sv */
// Self-checking testbench of the fixed packet record packetizer top level.
//
// The sender offers input items on the valid/stall channel, and the receiver
// takes result items on the output channel with random stalls. Every accepted
// input item goes through a packing predictor kept in this file. The predictor
// holds its own packet image, fill level, open flag and count of record bytes
// still due. The results it works out are queued, and the receiver compares
// each accepted result, field by field, with the oldest queued one.
//
// The run starts with a short directed table. It covers misuse while closed,
// the record size limit with and without a timestamp, surplus data bytes,
// abandoned records, open while open, undefined operation codes and the field
// extremes. Random phases follow, each with its own tag settings and its own
// mix of sender gaps and receiver stalls. Last comes a pressure phase in which
// a long record start overflows a partly filled packet while the receiver
// holds off long enough to back the block up into its input.
module tb_fixed_packet_record_packetizer_top;
	import fpr_pkg::*;

	// Operation codes the block does not define; they must be ignored.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int DRAIN_LIMIT   = 50_000;
	// Covers the start of a new packet after the final word of an emission.
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_ITEMS   = 55;
	// Longest record body that is sent in full.
	localparam int MAX_BODY      = 40;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  tag;
		logic [8:0]  len;
		logic [7:0]  data;
		logic [63:0] tv;
		logic        tvalid;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] word;
		logic        last;
		logic [1:0]  code;
	} result_t;

	// A directed row either carries its error report typed in (fixed) or is
	// left to the predictor.
	typedef struct packed {
		in_item_t it;
		logic     fixed;
		err_t     code;
	} dir_row_t;

	localparam logic [63:0] T_ONES = '1;
	localparam logic [63:0] T_MIX  = 64'h0123_4567_89AB_CDEF;
	localparam int N_DIR = 26;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// Every defined operation but open is refused while closed.
		'{'{OP_DATA,      8'h00, 9'd0,   8'h5A, 64'd0,  1'b0}, 1'b1, ERR_NOT_OPEN},
		'{'{OP_RECORD,    8'hFF, 9'd511, 8'h00, T_ONES, 1'b1}, 1'b1, ERR_NOT_OPEN},
		'{'{OP_FLUSH,     8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b1, ERR_NOT_OPEN},
		'{'{OP_CLOSE,     8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b1, ERR_NOT_OPEN},
		'{'{OP_UNUSED_LO, 8'hFF, 9'd511, 8'hFF, T_ONES, 1'b1}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_OPEN,      8'h00, 9'd0,   8'h00, T_ONES, 1'b1}, 1'b0, ERR_NOT_OPEN},
		// One byte over the limit with a timestamp header.
		'{'{OP_RECORD,    8'hFF, 9'd502, 8'h00, 64'd0,  1'b1}, 1'b1, ERR_TOO_LARGE},
		'{'{OP_RECORD,    8'h00, 9'd3,   8'h00, 64'd0,  1'b1}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'hFF, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'hA5, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'h3C, 64'd0,  1'b0}, 1'b1, ERR_UNEXPECTED},
		// The longest length never fits, even without a timestamp.
		'{'{OP_RECORD,    8'hAA, 9'd511, 8'h00, 64'd0,  1'b0}, 1'b1, ERR_TOO_LARGE},
		// This record is cut short by the next record start.
		'{'{OP_RECORD,    8'h55, 9'd2,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'h01, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_RECORD,    8'h3C, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_FLUSH,     8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'h77, 64'd0,  1'b0}, 1'b1, ERR_UNEXPECTED},
		// Open while open throws the packet away and starts over.
		'{'{OP_OPEN,      8'h00, 9'd0,   8'h00, T_MIX,  1'b1}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_UNUSED_HI, 8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_RECORD,    8'h81, 9'd1,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_DATA,      8'h00, 9'd0,   8'h7E, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_CLOSE,     8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_UNUSED_LO, 8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		// A packet of nothing but the sync tag and padding.
		'{'{OP_OPEN,      8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN},
		'{'{OP_CLOSE,     8'h00, 9'd0,   8'h00, 64'd0,  1'b0}, 1'b0, ERR_NOT_OPEN}
	};

	localparam int PH_IDLE  [4] = '{0, 53, 0, 22};
	localparam int PH_STALL [4] = '{0, 0, 53, 22};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           operation = '0;
	logic [7:0]           record_tag = '0;
	logic [8:0]           record_length = '0;
	logic [7:0]           data_byte = '0;
	logic [63:0]          time_value = '0;
	logic                 time_valid = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 kind;
	logic [63:0]          packet_word;
	logic                 last;
	logic [1:0]           error;

	fixed_packet_record_packetizer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.record_tag    (record_tag),
		.record_length (record_length),
		.data_byte     (data_byte),
		.time_value    (time_value),
		.time_valid    (time_valid),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.packet_word   (packet_word),
		.last          (last),
		.error         (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Packing predictor state: tag settings, the packet image and its bookkeeping.
	logic [7:0]  sync_tag_q = SYNC_TAG_RST;
	logic [7:0]  ts_tag_q   = TS_TAG_RST;
	logic [7:0]  pad_tag_q  = PAD_TAG_RST;
	logic [7:0]  pkt_image [PACKET_BYTES];
	int unsigned fill = 0;
	bit          opened = 1'b0;
	int unsigned bytes_due = 0;

	result_t pack_out [$];   // results of the item being predicted
	result_t due_out [$];    // results the block still owes, oldest first

	bit      failed = 1'b0;
	int      items_sent = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      cycle_count = 0;
	bit      hold_req = 1'b0;
	bit      hold_seen = 1'b0;
	int      hold_left = 0;
	result_t want;

	function automatic void put_byte(logic [7:0] b);
		if (fill < PACKET_BYTES) begin
			pkt_image[fill] = b;
			fill++;
		end
	endfunction

	function automatic void start_packet(logic [63:0] tv, logic tvalid);
		fill = 0;
		put_byte(sync_tag_q);
		if (tvalid) begin
			put_byte(ts_tag_q);
			for (int i = 0; i < 8; i++) put_byte(tv[8*i +: 8]);
		end
	endfunction

	// A full packet gets no padding at all, not even the padding tag.
	function automatic void pad_packet();
		if (fill >= PACKET_BYTES) return;
		put_byte(pad_tag_q);
		while (fill < PACKET_BYTES) put_byte(PAD_FILL);
	endfunction

	function automatic void emit_packet();
		result_t r;
		for (int w = 0; w < WORD_COUNT; w++) begin
			r = '0;
			r.kind = KIND_WORD;
			for (int k = 0; k < 8; k++) begin
				if (8*w + k < PACKET_BYTES) r.word[8*k +: 8] = pkt_image[8*w + k];
			end
			r.last = (w == WORD_COUNT - 1);
			pack_out.push_back(r);
		end
	endfunction

	function automatic void report_error(err_t code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.code = code;
		pack_out.push_back(r);
	endfunction

	// Works out the results of one accepted item into pack_out.
	function automatic void pack_item(in_item_t it);
		int need;
		int hdr;
		pack_out.delete();
		need = int'(it.len) + 1;
		hdr = it.tvalid ? HDR_TS : HDR_PLAIN;
		if (it.op > OP_CLOSE) return;
		if (it.op == OP_OPEN) begin
			opened = 1'b1;
			bytes_due = 0;
			start_packet(it.tv, it.tvalid);
			return;
		end
		if (!opened) begin
			report_error(ERR_NOT_OPEN);
			return;
		end
		case (it.op)
			OP_RECORD: begin
				bytes_due = 0;
				if (need > PACKET_BYTES - hdr) begin
					report_error(ERR_TOO_LARGE);
					return;
				end
				if (need > PACKET_BYTES - int'(fill)) begin
					pad_packet();
					emit_packet();
					start_packet(it.tv, it.tvalid);
				end
				put_byte(it.tag);
				bytes_due = 32'(it.len);
			end
			OP_DATA: begin
				if (bytes_due == 0 || fill >= PACKET_BYTES) begin
					report_error(ERR_UNEXPECTED);
				end else begin
					put_byte(it.data);
					bytes_due--;
				end
			end
			OP_FLUSH: begin
				bytes_due = 0;
				pad_packet();
				emit_packet();
				start_packet(it.tv, it.tvalid);
			end
			default: begin
				bytes_due = 0;
				pad_packet();
				emit_packet();
				opened = 1'b0;
			end
		endcase
	endfunction

	function automatic in_item_t random_fields(logic [2:0] op);
		in_item_t it;
		it.op = op;
		it.tag = 8'($urandom);
		it.len = 9'($urandom);
		it.data = 8'($urandom);
		it.tv = {$urandom, $urandom};
		it.tvalid = 1'($urandom);
		return it;
	endfunction

	// Mostly short records, some long ones, and now and then one near the limit.
	function automatic logic [8:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 9'($urandom_range(12));
		if (r < 85) return 9'($urandom_range(80, 13));
		if (r < 97) return 9'($urandom_range(300, 81));
		return 9'($urandom_range(511, 301));
	endfunction

	// Offers one item, waits for it to be taken and queues what it should cause.
	// A fixed row queues its typed-in error report instead of the prediction.
	task automatic offer(in_item_t it, bit fixed = 1'b0, err_t code = ERR_NOT_OPEN);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= it.op;
		record_tag    <= it.tag;
		record_length <= it.len;
		data_byte     <= it.data;
		time_value    <= it.tv;
		time_valid    <= it.tvalid;
		do @(posedge clk); while (in_stall);
		pack_item(it);
		if (fixed) begin
			r = '0;
			r.kind = KIND_ERROR;
			r.code = code;
			due_out.push_back(r);
		end else begin
			foreach (pack_out[i]) due_out.push_back(pack_out[i]);
		end
		if (it.op <= OP_CLOSE) items_sent++;
	endtask

	// Lowers valid, waits for every owed result, then lets the block settle.
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (due_out.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (due_out.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, due_out.size());
			failed = 1'b1;
			due_out.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tags(logic [7:0] s, logic [7:0] t, logic [7:0] p);
		cfg_write <= 1'b1;
		cfg_index <= CFG_SYNC_TAG;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= CFG_TS_TAG;
		cfg_data  <= t;
		@(posedge clk);
		cfg_index <= CFG_PAD_TAG;
		cfg_data  <= p;
		@(posedge clk);
		cfg_write <= 1'b0;
		sync_tag_q = s;
		ts_tag_q   = t;
		pad_tag_q  = p;
	endtask

	task automatic noise_item();
		offer(random_fields(3'($urandom_range(OP_UNUSED_HI))));
	endtask

	// One record: its start, then its data bytes, sometimes cut short. Long
	// bodies are cut short too, and the next item abandons the rest. A record
	// that will be refused gets only a few bytes, which come back as surplus.
	task automatic send_record(logic [8:0] len, logic tvalid);
		in_item_t it;
		int cut;
		int hdr;
		it = random_fields(OP_RECORD);
		it.len = len;
		it.tvalid = tvalid;
		hdr = tvalid ? HDR_TS : HDR_PLAIN;
		cut = int'(len);
		if ($urandom_range(19) == 0) cut = int'($urandom_range(len));
		if (cut > MAX_BODY) cut = int'($urandom_range(MAX_BODY));
		if (int'(len) + 1 > PACKET_BYTES - hdr && cut > 3) cut = 3;
		offer(it);
		repeat (cut) offer(random_fields(OP_DATA));
	endtask

	// A well-formed session: open, a few records with the odd flush or stray
	// item between them, and usually a close.
	task automatic session();
		int n_rec;
		int r;
		offer(random_fields(OP_OPEN));
		n_rec = $urandom_range(5, 1);
		repeat (n_rec) begin
			if ($urandom_range(19) == 0) noise_item();
			send_record(pick_length(), 1'($urandom));
			if ($urandom_range(7) == 0) offer(random_fields(OP_FLUSH));
		end
		r = $urandom_range(99);
		if (r < 70) offer(random_fields(OP_CLOSE));
		else if (r < 85) offer(random_fields(OP_FLUSH));
	endtask

	// Result checker and receiver stall. A toggle of hold_req starts a long
	// hold-off counted down here; otherwise stalls are drawn at stall_pct.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_out.size() == 0) begin
				failed = 1'b1;
				$display("%0t: result with none expected: kind=%0d word=%h last=%0d error=%0d",
					$time, kind, packet_word, last, error);
			end else begin
				want = due_out.pop_front();
				if (kind !== want.kind || packet_word !== want.word ||
						last !== want.last || error !== want.code) begin
					failed = 1'b1;
					$display("%0t: mismatch: expected kind=%0d word=%h last=%0d error=%0d",
						$time, want.kind, want.word, want.last, want.code);
					$display("%0t:           actual kind=%0d word=%h last=%0d error=%0d",
						$time, kind, packet_word, last, error);
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run did not finish in time", $time);
			$display("tb_fixed_packet_record_packetizer_top NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		in_item_t it;
		int goal;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, run on the reset tag values.
		for (int i = 0; i < N_DIR; i++) begin
			offer(DIR_ROWS[i].it, DIR_ROWS[i].fixed, DIR_ROWS[i].code);
		end
		drain();

		// Random phases. The first and last use opposite extreme sync and timestamp tags.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0) set_tags(8'hFF, 8'h00, 8'h00);
			else if (ph == 3) set_tags(8'h00, 8'hFF, 8'h80);
			else set_tags(8'($urandom), 8'($urandom), 8'($urandom));
			idle_pct = PH_IDLE[ph];
			stall_pct <= PH_STALL[ph];
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(9) == 0) noise_item();
				else session();
			end
			drain();
		end

		// Pressure: a long record start overflows a partly filled packet while
		// the receiver holds off, so the emission backs up into the input.
		set_tags(8'($urandom), 8'($urandom), 8'($urandom));
		idle_pct = 0;
		stall_pct <= 0;
		it = random_fields(OP_OPEN);
		it.tvalid = 1'b0;
		offer(it);
		it = random_fields(OP_RECORD);
		it.len = 9'd12;
		it.tvalid = 1'b0;
		offer(it);
		repeat (12) offer(random_fields(OP_DATA));
		hold_req <= ~hold_req;
		// Fourteen bytes are in, so this record start pads and emits first.
		it = random_fields(OP_RECORD);
		it.len = 9'd500;
		it.tvalid = 1'b1;
		offer(it);
		repeat (3) offer(random_fields(OP_DATA));
		offer(random_fields(OP_CLOSE));
		drain();

		if (!failed) begin
			$display("tb_fixed_packet_record_packetizer_top OK");
		end else begin
			$display("tb_fixed_packet_record_packetizer_top NOT OK");
		end
		$finish;
	end

endmodule
